>>> src/rlkd_pkg.sv
// Shared types and constants for the resistor ladder key debouncer.
`timescale 1ns / 1ps
`default_nettype none
package rlkd_pkg;

   localparam int SampleW    = 10;
   localparam int TimeW      = 32;
   localparam int KeyW       = 3;
   localparam int NumKeys    = 7;
   localparam int CsrIdxW    = 4;
   localparam int ReqDataW   = 48;
   localparam int RspDataW   = 8;

   localparam int DefDebounceMs = 50;
   localparam int DefLockoutMs  = 250;
   localparam int DefSampleBits = 10;

   localparam logic [CsrIdxW-1:0] CSR_KEY1_CENTRE  = 4'd0;
   localparam logic [CsrIdxW-1:0] CSR_HALF_WIDTH   = 4'd7;

   localparam logic [SampleW-1:0] DefCentreStep = 10'd128;
   localparam logic [SampleW-1:0] DefHalfWidth  = 10'd40;

   localparam logic [KeyW-1:0] KEY_NONE = 3'd0;

   typedef logic [SampleW-1:0] sample_type;
   typedef logic [TimeW-1:0]   time_type;
   typedef logic [KeyW-1:0]    key_type;

   typedef struct packed {
      logic     fire;
      time_type now_ms;
   } step_type;

   typedef struct packed {
      logic paused;
      logic awaiting;
   } status_type;

endpackage
`default_nettype wire

>>> src/rlkd_classify.sv
// Window classifier mapping one ladder sample to a key number.
`timescale 1ns / 1ps
`default_nettype none
module rlkd_classify #(
   parameter int SAMPLE_BITS = rlkd_pkg::DefSampleBits
) (
   input  wire rlkd_pkg::sample_type sample,
   input  wire rlkd_pkg::sample_type centre [rlkd_pkg::NumKeys],
   input  wire rlkd_pkg::sample_type half_width,
   output rlkd_pkg::key_type         key
);

   localparam logic [rlkd_pkg::SampleW-1:0] SampleMask =
      rlkd_pkg::SampleW'((64'(1) << SAMPLE_BITS) - 64'(1));

   logic signed [rlkd_pkg::SampleW+1:0] v_s;
   logic signed [rlkd_pkg::SampleW+1:0] h_s;
   logic signed [rlkd_pkg::SampleW+1:0] d_s [rlkd_pkg::NumKeys];
   logic [rlkd_pkg::NumKeys-1:0]        hit;

   always_comb begin
      v_s = signed'({2'b00, sample & SampleMask});
      h_s = signed'({2'b00, half_width & SampleMask});
      for (int k = 0; k < rlkd_pkg::NumKeys; k++) begin
         d_s[k] = v_s - signed'({2'b00, centre[k] & SampleMask});
         hit[k] = (d_s[k] < h_s) && (d_s[k] > -h_s);
      end
   end

   always_comb begin
      key = rlkd_pkg::KEY_NONE;
      for (int k = rlkd_pkg::NumKeys - 1; k >= 0; k--) begin
         if (hit[k]) begin
            key = rlkd_pkg::KeyW'(k + 1);
         end
      end
   end

endmodule
`default_nettype wire

>>> src/rlkd_debounce.sv
// Two-phase debounce and lockout state with per-poll key decision.
`timescale 1ns / 1ps
`default_nettype none
module rlkd_debounce #(
   parameter int DEBOUNCE_MS = rlkd_pkg::DefDebounceMs,
   parameter int LOCKOUT_MS  = rlkd_pkg::DefLockoutMs
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire rlkd_pkg::step_type   step,
   input  wire rlkd_pkg::key_type    cls_key,
   output rlkd_pkg::key_type         rpt_key,
   output rlkd_pkg::status_type      status
);

   localparam rlkd_pkg::time_type DebounceLim = rlkd_pkg::TimeW'(DEBOUNCE_MS);
   localparam rlkd_pkg::time_type LockoutLim  = rlkd_pkg::TimeW'(LOCKOUT_MS);

   rlkd_pkg::key_type  latched_ff, latched_in;
   logic               await_ff, await_in;
   logic               paused_ff, paused_in;
   rlkd_pkg::time_type dstart_ff, dstart_in;
   rlkd_pkg::time_type lstart_ff, lstart_in;

   always_comb begin
      latched_in = latched_ff;
      await_in   = await_ff;
      paused_in  = paused_ff;
      dstart_in  = dstart_ff;
      lstart_in  = lstart_ff;
      rpt_key    = rlkd_pkg::KEY_NONE;
      if (!paused_ff) begin
         if (await_ff) begin
            latched_in = cls_key;
            dstart_in  = step.now_ms;
            await_in   = 1'b0;
         end
         if ((step.now_ms - dstart_in) > DebounceLim) begin
            if (cls_key == latched_in) begin
               rpt_key = cls_key;
            end
            latched_in = rlkd_pkg::KEY_NONE;
            await_in   = 1'b1;
            dstart_in  = step.now_ms;
         end
      end
      if ((step.now_ms - lstart_ff) > LockoutLim) begin
         paused_in = 1'b0;
         lstart_in = step.now_ms;
      end
      if (rpt_key != rlkd_pkg::KEY_NONE) begin
         paused_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= rlkd_pkg::KEY_NONE;
         await_ff   <= 1'b1;
         paused_ff  <= 1'b0;
         dstart_ff  <= '0;
         lstart_ff  <= '0;
      end else if (step.fire) begin
         latched_ff <= latched_in;
         await_ff   <= await_in;
         paused_ff  <= paused_in;
         dstart_ff  <= dstart_in;
         lstart_ff  <= lstart_in;
      end
   end

   assign status.paused   = paused_ff;
   assign status.awaiting = await_ff;

endmodule
`default_nettype wire

>>> src/resistor_ladder_key_debouncer.sv
// Top level of the resistor ladder key debouncer.
//
// Usage: each req beat is one poll carrying a converter sample and a
// wrapping millisecond time. Each poll gives exactly one rsp beat with the
// debounced key, 1 to 7, or 0 when nothing is reported this poll.
// A poll accepted into the input register is decided combinationally from it,
// and its key is captured into the result register once the rsp side advances.
// Throughput: one poll per cycle unless rsp stalls; the decision is one pass of
// seven window compares and two 32-bit wrapping subtracts against the debounce
// state. A stalled rsp side holds the result register; the input register still
// takes one more beat, then req_tready drops until rsp_tready returns.
// csr writes are taken every cycle (csr_ready is always high): index 0 to 6
// set the key centres, index 7 the window half width, others are dropped.
// Write them only while no poll is in flight.
// Reset: centres return to 128 through 896, half width to 40, debounce
// restarts awaiting its first read, lockout is cleared, both registers empty.
`timescale 1ns / 1ps
`default_nettype none
module resistor_ladder_key_debouncer #(
   parameter int DEBOUNCE_MS = rlkd_pkg::DefDebounceMs,
   parameter int LOCKOUT_MS  = rlkd_pkg::DefLockoutMs,
   parameter int SAMPLE_BITS = rlkd_pkg::DefSampleBits
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [rlkd_pkg::ReqDataW-1:0]      req_tdata,   // sample[9:0], now_ms[41:10]
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [rlkd_pkg::RspDataW-1:0]     rsp_tdata,   // key[2:0]
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [rlkd_pkg::CsrIdxW-1:0]       csr_index,
   input  wire [rlkd_pkg::SampleW-1:0]       csr_wdata
);

   rlkd_pkg::sample_type centre_ff [rlkd_pkg::NumKeys];
   rlkd_pkg::sample_type half_ff;

   logic                 in_valid_ff;
   rlkd_pkg::sample_type in_sample_ff;
   rlkd_pkg::time_type   in_now_ff;

   logic                 rsp_valid_ff;
   rlkd_pkg::key_type    rsp_key_ff;

   logic                 advance;
   rlkd_pkg::step_type   step;
   rlkd_pkg::key_type    cls_key;
   rlkd_pkg::key_type    rpt_key;
   rlkd_pkg::status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rlkd_pkg::NumKeys; k++) begin
            centre_ff[k] <= rlkd_pkg::SampleW'(rlkd_pkg::DefCentreStep * (k + 1));
         end
         half_ff <= rlkd_pkg::DefHalfWidth;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == rlkd_pkg::CSR_HALF_WIDTH) begin
            half_ff <= csr_wdata;
         end else if (csr_index < rlkd_pkg::CSR_HALF_WIDTH) begin
            centre_ff[3'(csr_index - rlkd_pkg::CSR_KEY1_CENTRE)] <= csr_wdata;
         end
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sample_ff <= req_tdata[rlkd_pkg::SampleW-1:0];
         in_now_ff    <= req_tdata[rlkd_pkg::SampleW +: rlkd_pkg::TimeW];
      end
   end

   assign step.fire   = in_valid_ff && advance;
   assign step.now_ms = in_now_ff;

   rlkd_classify #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_classify (
      .sample     (in_sample_ff),
      .centre     (centre_ff),
      .half_width (half_ff),
      .key        (cls_key)
   );

   rlkd_debounce #(
      .DEBOUNCE_MS (DEBOUNCE_MS),
      .LOCKOUT_MS  (LOCKOUT_MS)
   ) u_debounce (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .cls_key (cls_key),
      .rpt_key (rpt_key),
      .status  (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step.fire) begin
         rsp_key_ff <= rpt_key;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rlkd_pkg::RspDataW - rlkd_pkg::KeyW){1'b0}}, rsp_key_ff};

   a_fire_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step.fire |=> rsp_valid_ff)
      else $error("decided poll did not reach the result register");

   a_report_pauses: assert property (@(posedge clock) disable iff (reset)
      step.fire && (rpt_key != rlkd_pkg::KEY_NONE) |=> status.paused)
      else $error("reported key did not start lockout");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input side stalled without a full pipe");

   a_paused_silent: assert property (@(posedge clock) disable iff (reset)
      step.fire && status.paused |-> (rpt_key == rlkd_pkg::KEY_NONE))
      else $error("key reported while paused");

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the resistor ladder key debouncer.
`timescale 1ns / 1ps
module testbench;

   localparam logic [rlkd_pkg::CsrIdxW-1:0] CsrFirstUnused =
      rlkd_pkg::CSR_HALF_WIDTH + 4'd1;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 4;

   class debounce_scoreboard;
      rlkd_pkg::sample_type centre[rlkd_pkg::NumKeys];
      rlkd_pkg::sample_type half;
      rlkd_pkg::key_type    latched;
      bit                   awaiting;
      rlkd_pkg::time_type   debounce_t0;
      bit                   paused;
      rlkd_pkg::time_type   lockout_t0;
      rlkd_pkg::key_type    expected_keys[$];
      int                   errors;

      function new();
         for (int k = 0; k < rlkd_pkg::NumKeys; k++) begin
            centre[k] = rlkd_pkg::sample_type'(rlkd_pkg::DefCentreStep * (k + 1));
         end
         half        = rlkd_pkg::DefHalfWidth;
         latched     = rlkd_pkg::KEY_NONE;
         awaiting    = 1'b1;
         debounce_t0 = '0;
         paused      = 1'b0;
         lockout_t0  = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [rlkd_pkg::CsrIdxW-1:0] idx,
                              rlkd_pkg::sample_type value);
         if (idx < rlkd_pkg::CSR_HALF_WIDTH) begin
            centre[idx - rlkd_pkg::CSR_KEY1_CENTRE] = value;
         end else if (idx == rlkd_pkg::CSR_HALF_WIDTH) begin
            half = value;
         end
      endfunction

      function rlkd_pkg::key_type classify(rlkd_pkg::sample_type s);
         int v;
         int h;
         int c;
         v = int'(s);
         h = int'(half);
         for (int k = 0; k < rlkd_pkg::NumKeys; k++) begin
            c = int'(centre[k]);
            if (c - h < v && v < c + h) return rlkd_pkg::key_type'(k + 1);
         end
         return rlkd_pkg::KEY_NONE;
      endfunction

      function void note_poll(rlkd_pkg::sample_type s, rlkd_pkg::time_type t);
         rlkd_pkg::key_type  found;
         rlkd_pkg::time_type gap;
         found = rlkd_pkg::KEY_NONE;
         if (!paused) begin
            if (awaiting) begin
               latched     = classify(s);
               debounce_t0 = t;
               awaiting    = 1'b0;
            end
            gap = t - debounce_t0;
            if (gap > rlkd_pkg::time_type'(rlkd_pkg::DefDebounceMs)) begin
               if (classify(s) == latched) found = latched;
               latched     = rlkd_pkg::KEY_NONE;
               awaiting    = 1'b1;
               debounce_t0 = t;
            end
         end
         gap = t - lockout_t0;
         if (gap > rlkd_pkg::time_type'(rlkd_pkg::DefLockoutMs)) begin
            paused     = 1'b0;
            lockout_t0 = t;
         end
         if (found != rlkd_pkg::KEY_NONE) paused = 1'b1;
         expected_keys.push_back(found);
      endfunction

      function void check_key(rlkd_pkg::key_type got);
         rlkd_pkg::key_type want;
         if (expected_keys.size() == 0) begin
            $display("%0t: unexpected key beat, expected none, got %0d", $time, got);
            errors++;
         end else begin
            want = expected_keys.pop_front();
            if (got !== want) begin
               $display("%0t: key mismatch, expected %0d, got %0d", $time, want, got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_keys.size();
      endfunction
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rlkd_pkg::ReqDataW-1:0]  req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rlkd_pkg::RspDataW-1:0]  rsp_tdata;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [rlkd_pkg::CsrIdxW-1:0]   csr_index  = '0;
   logic [rlkd_pkg::SampleW-1:0]   csr_wdata  = '0;

   debounce_scoreboard sb = new();
   rlkd_pkg::time_type cur_ms = '0;
   bit                 calm = 1'b0;
   int                 stall_left = 0;
   int                 quiet_cycles = 0;

   resistor_ladder_key_debouncer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_key(rsp_tdata[rlkd_pkg::KeyW-1:0]);
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(logic [rlkd_pkg::CsrIdxW-1:0] idx, rlkd_pkg::sample_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
   endtask

   task automatic load_settings(rlkd_pkg::sample_type centres[rlkd_pkg::NumKeys],
                                rlkd_pkg::sample_type width);
      for (int k = 0; k < rlkd_pkg::NumKeys; k++) begin
         write_csr(rlkd_pkg::CsrIdxW'(rlkd_pkg::CSR_KEY1_CENTRE + k), centres[k]);
      end
      write_csr(rlkd_pkg::CSR_HALF_WIDTH, width);
      write_csr(rlkd_pkg::CsrIdxW'(CsrFirstUnused + $urandom_range(0, 7)),
                rlkd_pkg::sample_type'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic idle_req(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_poll(rlkd_pkg::sample_type s, rlkd_pkg::time_type t);
      if (!calm && $urandom_range(0, 7) == 0) idle_req($urandom_range(1, 15));
      req_tvalid <= 1'b1;
      req_tdata  <= {{(rlkd_pkg::ReqDataW - rlkd_pkg::TimeW - rlkd_pkg::SampleW){1'b0}},
                     t, s};
      do @(posedge clock); while (!req_tready);
      sb.note_poll(s, t);
   endtask

   function automatic rlkd_pkg::sample_type near_key(int k);
      int h;
      int v;
      int off;
      h = int'(sb.half);
      case ($urandom_range(0, 9))
         0: off = h;
         1: off = -h;
         default: off = (h == 0) ? 0 : int'($urandom_range(0, 2 * h - 2)) - (h - 1);
      endcase
      v = int'(sb.centre[k - 1]) + off;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return rlkd_pkg::sample_type'(v);
   endfunction

   task automatic run_polls(int count);
      int                   sent;
      int                   pick;
      int                   k;
      int                   n;
      rlkd_pkg::sample_type s;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            k = $urandom_range(1, rlkd_pkg::NumKeys);
            n = $urandom_range(2, 8);
            for (int i = 0; i < n && sent < count; i++) begin
               cur_ms += (i == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
               s = ($urandom_range(0, 11) == 0) ? rlkd_pkg::sample_type'($urandom)
                                                : near_key(k);
               send_poll(s, cur_ms);
               sent++;
            end
         end else if (pick < 18) begin
            cur_ms += $urandom_range(0, 400);
            send_poll(rlkd_pkg::sample_type'($urandom), cur_ms);
            sent++;
         end else begin
            cur_ms = $urandom();
            send_poll(rlkd_pkg::sample_type'($urandom), cur_ms);
            sent++;
         end
      end
   endtask

   task automatic run_directed();
      rlkd_pkg::sample_type c;
      send_poll(rlkd_pkg::sample_type'(0), 32'd0);
      send_poll(rlkd_pkg::sample_type'(1023), 32'd51);
      cur_ms = 32'd51;
      for (int k = 1; k <= rlkd_pkg::NumKeys; k++) begin
         c = sb.centre[k - 1];
         cur_ms += 300;
         send_poll(rlkd_pkg::sample_type'(0), cur_ms);
         send_poll(c, cur_ms + 1);
         cur_ms += 52;
         send_poll((k % 2 == 1) ? c + 10'd39 : c - 10'd39, cur_ms);
      end
      send_poll(rlkd_pkg::sample_type'(512), 32'hFFFF_FFF0);
      send_poll(rlkd_pkg::sample_type'(512), 32'hFFFF_FFFF);
      send_poll(rlkd_pkg::sample_type'(512), 32'h0000_0030);
      cur_ms = 32'h0000_0030;
   endtask

   initial begin
      rlkd_pkg::sample_type centres[rlkd_pkg::NumKeys];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_polls(330);
      drain();

      for (int k = 0; k < rlkd_pkg::NumKeys; k++) begin
         centres[k] = rlkd_pkg::sample_type'($urandom);
      end
      load_settings(centres, rlkd_pkg::sample_type'(0));
      run_polls(250);
      drain();

      for (int k = 0; k < rlkd_pkg::NumKeys; k++) begin
         centres[k] = (k % 2 == 0) ? rlkd_pkg::sample_type'(0)
                                   : rlkd_pkg::sample_type'(1023);
      end
      load_settings(centres, rlkd_pkg::sample_type'(1023));
      run_polls(150);
      drain();
      run_polls(150);
      drain();

      for (int k = 0; k < rlkd_pkg::NumKeys; k++) begin
         centres[k] = rlkd_pkg::sample_type'(500 + 10 * k);
      end
      load_settings(centres, rlkd_pkg::sample_type'(60));
      run_polls(300);
      drain();

      for (int k = 0; k < rlkd_pkg::NumKeys; k++) begin
         centres[k] = rlkd_pkg::sample_type'($urandom);
      end
      load_settings(centres, rlkd_pkg::sample_type'($urandom_range(1, 120)));
      calm = 1'b1;
      run_polls(450);
      drain();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
